### src/dnsuf_pkg.sv
// Package for the DNS-over-UDP frame filter: constants, phase codes and beat types.
// Has no dependencies. The parser, queue, top level and checker all import it.
`timescale 1ns / 1ps

package dnsuf_pkg;

  localparam int PAYLOAD_MAX = 512;
  localparam int CNT_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int LEN_W       = 10;
  localparam int OFF_W       = 7;
  localparam int MIN_KEPT    = 12;
  localparam int ETH_HDR_LEN = 14;
  localparam int UDP_HDR_LEN = 8;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int M_TDATA_W   = 56;

  localparam logic [7:0]  ETYPE_HI   = 8'h08;
  localparam logic [7:0]  ETYPE_LO   = 8'h00;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MIN    = 4'd5;
  localparam logic [15:0] PORT_RESET = 16'd53;

  typedef enum logic [2:0] {
    PH_ETH     = 3'd0,
    PH_IP      = 3'd1,
    PH_UDP     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DROP    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload_byte;
    logic [15:0]       source_port;
    logic [15:0]       dest_port;
    logic [LEN_W-1:0]  payload_length;
    logic              run_last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

### src/dnsuf_parser.sv
// Header parser: walks Ethernet, IPv4 and UDP headers and builds up to two result beats.
// Depends on dnsuf_pkg.
`timescale 1ns / 1ps

module dnsuf_parser import dnsuf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] match_port_i,
  output push_t       push_o
);

  phase_e             phase_q, phase_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [3:0]         words_q, words_d;
  logic [15:0]        sp_q, sp_d, dp_q, dp_d;
  logic [CNT_W-1:0]   kept_q, kept_d;

  logic [OFF_W-1:0]   off_inc;
  logic [3:0]         words_eff;
  logic [OFF_W-1:0]   ip_len;
  logic               pay_valid;
  res_t               pay_res, evt_res;

  always_comb begin
    phase_d   = phase_q;
    off_d     = off_q;
    words_d   = words_q;
    sp_d      = sp_q;
    dp_d      = dp_q;
    kept_d    = kept_q;
    pay_valid = 1'b0;
    off_inc   = off_q + OFF_W'(1);
    words_eff = (off_q == '0) ? data_byte_i[3:0] : words_q;
    ip_len    = OFF_W'({words_eff, 2'b00});

    unique case (phase_q)
      PH_ETH: begin
        if ((off_q == OFF_W'(12) && data_byte_i != ETYPE_HI) ||
            (off_q == OFF_W'(13) && data_byte_i != ETYPE_LO)) begin
          phase_d = PH_DROP;
        end else if (off_inc >= OFF_W'(ETH_HDR_LEN)) begin
          phase_d = PH_IP;
          off_d   = '0;
        end else begin
          off_d = off_inc;
        end
      end
      PH_IP: begin
        words_d = words_eff;
        if (off_q == '0 && words_eff < IHL_MIN) begin
          phase_d = PH_DROP;
        end else if (off_q == OFF_W'(9) && data_byte_i != PROTO_UDP) begin
          phase_d = PH_DROP;
        end else if (off_inc >= ip_len) begin
          phase_d = PH_UDP;
          off_d   = '0;
        end else begin
          off_d = off_inc;
        end
      end
      PH_UDP: begin
        case (off_q)
          OFF_W'(0): sp_d = {data_byte_i, 8'h00};
          OFF_W'(1): sp_d = {sp_q[15:8], data_byte_i};
          OFF_W'(2): dp_d = {data_byte_i, 8'h00};
          OFF_W'(3): dp_d = {dp_q[15:8], data_byte_i};
          default:   ;
        endcase
        if (off_inc >= OFF_W'(UDP_HDR_LEN)) begin
          off_d  = '0;
          kept_d = '0;
          if (sp_q == match_port_i || dp_q == match_port_i) begin
            phase_d = PH_PAYLOAD;
          end else begin
            phase_d = PH_DROP;
          end
        end else begin
          off_d = off_inc;
        end
      end
      PH_PAYLOAD: begin
        if (kept_q < CNT_W'(PAYLOAD_MAX)) begin
          pay_valid = 1'b1;
          kept_d    = kept_q + CNT_W'(1);
        end
      end
      default: ;
    endcase

    pay_res                = '0;
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.payload_byte   = data_byte_i;
    pay_res.run_last       = !(frame_end_i && phase_d == PH_PAYLOAD);

    evt_res                = '0;
    evt_res.payload_length = LEN_W'(kept_d);
    evt_res.run_last       = 1'b1;
    if (kept_d < CNT_W'(MIN_KEPT)) begin
      evt_res.kind = KIND_DISCARD;
    end else begin
      evt_res.kind        = KIND_COMMIT;
      evt_res.source_port = sp_d;
      evt_res.dest_port   = dp_d;
    end

    push_o = '0;
    if (accept_i) begin
      if (pay_valid) begin
        push_o.first  = pay_res;
        push_o.second = evt_res;
        push_o.count  = (frame_end_i && phase_d == PH_PAYLOAD) ? 2'd2 : 2'd1;
      end else if (frame_end_i && phase_d == PH_PAYLOAD) begin
        push_o.first = evt_res;
        push_o.count = 2'd1;
      end
    end

    if (frame_end_i) begin
      phase_d = PH_ETH;
      off_d   = '0;
      words_d = '0;
      sp_d    = '0;
      dp_d    = '0;
      kept_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ETH;
      off_q   <= '0;
      words_q <= '0;
      sp_q    <= '0;
      dp_q    <= '0;
      kept_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      words_q <= words_d;
      sp_q    <= sp_d;
      dp_q    <= dp_d;
      kept_q  <= kept_d;
    end
  end

endmodule

### src/dnsuf_queue.sv
// Result queue: takes up to two beats a cycle, hands out one beat a cycle while ready_i is high.
// Depends on dnsuf_pkg.
`timescale 1ns / 1ps

module dnsuf_queue import dnsuf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  res_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [Q_PTR_W-1:0] wr_next;

  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= Q_CNT_W'(Q_DEPTH - 2);
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + Q_PTR_W'(1);

  always_comb begin
    wr_d  = wr_q + Q_PTR_W'(push_i.count);
    rd_d  = pop ? rd_q + Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(push_i.count) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### src/dns_over_udp_frame_filter.sv
// Top level of the DNS-over-UDP frame filter: port register, parser and result queue.
// Depends on dnsuf_pkg, dnsuf_parser and dnsuf_queue.
//
//   channel  | direction | tdata                                   | tuser | tlast
//   s_axis   | in        | data_byte                               | -     | frame_end
//   m_axis   | out       | payload_byte, source_port, dest_port,   | kind  | run_last
//            |           | payload_length                          |       |
//   cfg      | in        | match_port on cfg_we_i                  | -     | -
//
// One frame byte is taken per cycle while s_axis_tready is high; its results land in the queue on the same edge.
// A payload byte that also ends the frame gives two beats, drained one per cycle while m_axis_tready is high.
// s_axis_tready drops while the four-entry queue has fewer than two free slots.
// Reset returns the parser to the Ethernet header phase and sets match_port to 53.
`timescale 1ns / 1ps

module dns_over_udp_frame_filter import dnsuf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] source_port,
                                               // [39:24] dest_port, [49:40] payload_length
  output logic [1:0]           m_axis_tuser,   // [1:0] kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);

  logic [15:0] match_port_q;
  logic        accept;
  push_t       push;
  res_t        head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= PORT_RESET;
    end else if (cfg_we_i) begin
      match_port_q <= cfg_wdata_i;
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  dnsuf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .frame_end_i  (s_axis_tlast),
    .match_port_i (match_port_q),
    .push_o       (push)
  );

  dnsuf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = M_TDATA_W'({head.payload_length, head.dest_port,
                                    head.source_port, head.payload_byte});
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_last;

endmodule

### src/dnsuf_chk.sv
// Port checker for the DNS-over-UDP frame filter, bound to the top level.
// Depends on dnsuf_pkg and dns_over_udp_frame_filter.
`timescale 1ns / 1ps

module dnsuf_chk import dnsuf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]           m_axis_tuser,
  input logic                 m_axis_tlast
);

  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD || m_axis_tuser == KIND_COMMIT ||
                       m_axis_tuser == KIND_DISCARD))
    else $error("unknown result kind");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_PAYLOAD |-> m_axis_tdata[M_TDATA_W-1:8] == '0)
    else $error("payload beat carries event fields");

  a_event_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD |->
      m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
    else $error("event beat not last or carries a byte");

  a_discard_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DISCARD |->
      m_axis_tdata[49:40] < LEN_W'(MIN_KEPT) && m_axis_tdata[39:8] == '0)
    else $error("discard beat with long length or ports");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled beat changed");

endmodule

bind dns_over_udp_frame_filter dnsuf_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
